/* rtl/drm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

  localparam int QW     = 48;            // state word width, signed Q16.32
  localparam int OPW    = QW + 1;        // operand width: signed state or unsigned coefficient
  localparam int ACCW   = QW + 3;        // accumulator width, six terms without wrap
  localparam int SAMPW  = 24;            // Q1.23 sample width
  localparam int SAMP_SHIFT = 9;         // Q1.23 -> Q16.32
  localparam int NREG   = 19;            // working registers in the state file
  localparam int RAW    = 5;             // state file address width
  localparam int PROG_LEN = 81;          // micro-ops per sample
  localparam int PCW    = 7;
  localparam int CIDXW  = 3;             // configuration index width
  localparam int NCFG   = 6;

  localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic [QW-1:0] K_POINT2  = 48'd858993459;
  localparam logic [QW-1:0] K_POINT17 = 48'd730144440;

  localparam logic [QW-1:0] RST_STEP_OVER_C  = 48'd9739154880000;
  localparam logic [QW-1:0] RST_STEP_OVER_CP = 48'd9739154880000;
  localparam logic [QW-1:0] RST_STEP_OVER_L  = 48'd121743;
  localparam logic [QW-1:0] RST_INV_LOAD_R   = 48'd7158279;
  localparam logic [QW-1:0] RST_INV_CENTER_R = 48'd85899346;
  localparam logic [QW-1:0] RST_INV_MOD_R    = 48'd53687091;

  typedef enum logic [CIDXW-1:0] {
    CFG_STEP_OVER_C  = 3'd0,
    CFG_STEP_OVER_CP = 3'd1,
    CFG_STEP_OVER_L  = 3'd2,
    CFG_INV_LOAD_R   = 3'd3,
    CFG_INV_CENTER_R = 3'd4,
    CFG_INV_MOD_R    = 3'd5
  } cfg_idx_e;

  // Operand sources; the first NREG codes are state file addresses.
  typedef enum logic [RAW-1:0] {
    S_U1, S_U2, S_U3,
    S_V4, S_V5, S_V6, S_V7,
    S_I1, S_I2,
    S_D4, S_D5, S_D6, S_D7,
    S_DRY, S_MOD, S_PROD,
    S_TA, S_TB,
    S_TC,
    S_SC, S_SCP, S_SL, S_IRA, S_IRI, S_IRM,
    S_K02, S_K017, S_SDRY, S_SMOD
  } src_e;

  typedef enum logic [1:0] {
    K_MUL,
    K_ACC,
    K_ST,
    K_DONE
  } kind_e;

  typedef struct packed {
    kind_e kind;
    src_e  sa;
    src_e  sb;
    src_e  dst;
    logic  neg;
    logic  hlf;
    logic  clr;
  } uop_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_MULW,
    ST_OUT
  } state_e;

  function automatic uop_t op_mul(input src_e a, input src_e b, input src_e d);
    uop_t u;
    u = '{kind: K_MUL, sa: a, sb: b, dst: d, neg: 1'b0, hlf: 1'b0, clr: 1'b0};
    return u;
  endfunction

  function automatic uop_t op_acc(input src_e a, input logic c, input logic n,
                                  input logic h);
    uop_t u;
    u = '{kind: K_ACC, sa: a, sb: a, dst: a, neg: n, hlf: h, clr: c};
    return u;
  endfunction

  function automatic uop_t op_st(input src_e d);
    uop_t u;
    u = '{kind: K_ST, sa: d, sb: d, dst: d, neg: 1'b0, hlf: 1'b0, clr: 1'b0};
    return u;
  endfunction

  // Micro-program for one sample step.
  function automatic uop_t ucode(input logic [PCW-1:0] pc);
    uop_t u;
    u = '{kind: K_DONE, sa: S_U2, sb: S_U2, dst: S_U2, neg: 1'b0, hlf: 1'b0, clr: 1'b0};
    case (pc)
      // scaled samples
      7'd0:  u = op_mul(S_SDRY, S_K02, S_DRY);
      7'd1:  u = op_mul(S_SMOD, S_K02, S_MOD);
      // diode currents from the old diode voltages
      7'd2:  u = op_mul(S_V4, S_V4, S_D4);
      7'd3:  u = op_mul(S_D4, S_D4, S_D4);
      7'd4:  u = op_mul(S_D4, S_K017, S_D4);
      7'd5:  u = op_mul(S_V5, S_V5, S_D5);
      7'd6:  u = op_mul(S_D5, S_D5, S_D5);
      7'd7:  u = op_mul(S_D5, S_K017, S_D5);
      7'd8:  u = op_mul(S_V6, S_V6, S_D6);
      7'd9:  u = op_mul(S_D6, S_D6, S_D6);
      7'd10: u = op_mul(S_D6, S_K017, S_D6);
      7'd11: u = op_mul(S_V7, S_V7, S_D7);
      7'd12: u = op_mul(S_D7, S_D7, S_D7);
      7'd13: u = op_mul(S_D7, S_K017, S_D7);
      // bracket for u1
      7'd14: u = op_acc(S_U1, 1'b1, 1'b0, 1'b0);
      7'd15: u = op_acc(S_MOD, 1'b0, 1'b1, 1'b0);
      7'd16: u = op_st(S_TA);
      7'd17: u = op_mul(S_TA, S_IRM, S_PROD);
      7'd18: u = op_acc(S_I1, 1'b1, 1'b0, 1'b0);
      7'd19: u = op_acc(S_D4, 1'b0, 1'b1, 1'b1);
      7'd20: u = op_acc(S_D7, 1'b0, 1'b0, 1'b1);
      7'd21: u = op_acc(S_D5, 1'b0, 1'b0, 1'b1);
      7'd22: u = op_acc(S_D6, 1'b0, 1'b1, 1'b1);
      7'd23: u = op_acc(S_PROD, 1'b0, 1'b1, 1'b0);
      7'd24: u = op_st(S_TA);
      // bracket for u2
      7'd25: u = op_mul(S_U2, S_IRA, S_PROD);
      7'd26: u = op_acc(S_I2, 1'b1, 1'b0, 1'b0);
      7'd27: u = op_acc(S_D4, 1'b0, 1'b0, 1'b1);
      7'd28: u = op_acc(S_D7, 1'b0, 1'b0, 1'b1);
      7'd29: u = op_acc(S_D5, 1'b0, 1'b1, 1'b1);
      7'd30: u = op_acc(S_D6, 1'b0, 1'b1, 1'b1);
      7'd31: u = op_acc(S_PROD, 1'b0, 1'b1, 1'b0);
      7'd32: u = op_st(S_TB);
      // bracket for u3
      7'd33: u = op_mul(S_U3, S_IRI, S_PROD);
      7'd34: u = op_acc(S_D4, 1'b1, 1'b0, 1'b0);
      7'd35: u = op_acc(S_D7, 1'b0, 1'b1, 1'b0);
      7'd36: u = op_acc(S_D5, 1'b0, 1'b0, 1'b0);
      7'd37: u = op_acc(S_D6, 1'b0, 1'b1, 1'b0);
      7'd38: u = op_acc(S_PROD, 1'b0, 1'b1, 1'b0);
      7'd39: u = op_st(S_TC);
      // node voltage updates
      7'd40: u = op_mul(S_SC, S_TA, S_PROD);
      7'd41: u = op_acc(S_U1, 1'b1, 1'b0, 1'b0);
      7'd42: u = op_acc(S_PROD, 1'b0, 1'b0, 1'b0);
      7'd43: u = op_st(S_U1);
      7'd44: u = op_mul(S_SC, S_TB, S_PROD);
      7'd45: u = op_acc(S_U2, 1'b1, 1'b0, 1'b0);
      7'd46: u = op_acc(S_PROD, 1'b0, 1'b0, 1'b0);
      7'd47: u = op_st(S_U2);
      7'd48: u = op_mul(S_SCP, S_TC, S_PROD);
      7'd49: u = op_acc(S_U3, 1'b1, 1'b0, 1'b0);
      7'd50: u = op_acc(S_PROD, 1'b0, 1'b0, 1'b0);
      7'd51: u = op_st(S_U3);
      // diode voltages from the new node voltages
      7'd52: u = op_acc(S_U1, 1'b1, 1'b0, 1'b1);
      7'd53: u = op_acc(S_U3, 1'b0, 1'b1, 1'b0);
      7'd54: u = op_acc(S_DRY, 1'b0, 1'b1, 1'b0);
      7'd55: u = op_acc(S_U2, 1'b0, 1'b1, 1'b1);
      7'd56: u = op_st(S_V4);
      7'd57: u = op_acc(S_U1, 1'b1, 1'b1, 1'b1);
      7'd58: u = op_acc(S_U3, 1'b0, 1'b1, 1'b0);
      7'd59: u = op_acc(S_DRY, 1'b0, 1'b1, 1'b0);
      7'd60: u = op_acc(S_U2, 1'b0, 1'b0, 1'b1);
      7'd61: u = op_st(S_V5);
      7'd62: u = op_acc(S_U1, 1'b1, 1'b0, 1'b1);
      7'd63: u = op_acc(S_U3, 1'b0, 1'b0, 1'b0);
      7'd64: u = op_acc(S_DRY, 1'b0, 1'b0, 1'b0);
      7'd65: u = op_acc(S_U2, 1'b0, 1'b0, 1'b1);
      7'd66: u = op_st(S_V6);
      7'd67: u = op_acc(S_U1, 1'b1, 1'b1, 1'b1);
      7'd68: u = op_acc(S_U3, 1'b0, 1'b0, 1'b0);
      7'd69: u = op_acc(S_DRY, 1'b0, 1'b0, 1'b0);
      7'd70: u = op_acc(S_U2, 1'b0, 1'b1, 1'b1);
      7'd71: u = op_st(S_V7);
      // inductor currents
      7'd72: u = op_mul(S_SL, S_U1, S_PROD);
      7'd73: u = op_acc(S_I1, 1'b1, 1'b0, 1'b0);
      7'd74: u = op_acc(S_PROD, 1'b0, 1'b1, 1'b0);
      7'd75: u = op_st(S_I1);
      7'd76: u = op_mul(S_SL, S_U2, S_PROD);
      7'd77: u = op_acc(S_I2, 1'b1, 1'b0, 1'b0);
      7'd78: u = op_acc(S_PROD, 1'b0, 1'b1, 1'b0);
      7'd79: u = op_st(S_I2);
      default: u = '{kind: K_DONE, sa: S_U2, sb: S_U2, dst: S_U2,
                     neg: 1'b0, hlf: 1'b0, clr: 1'b0};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/drm_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface drm_in_if import drm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SAMPW-1:0] dry_sample;
  logic signed [SAMPW-1:0] mod_sample;
  logic                    end_of_block;

  modport source (output valid, dry_sample, mod_sample, end_of_block, input ready);
  modport sink   (input valid, dry_sample, mod_sample, end_of_block, output ready);
endinterface

`default_nettype wire

/* rtl/drm_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface drm_out_if import drm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] wet_sample;
  logic                 end_of_block_out;

  modport source (output valid, wet_sample, end_of_block_out, input ready);
  modport sink   (input valid, wet_sample, end_of_block_out, output ready);
endinterface

`default_nettype wire

/* rtl/drm_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial Q16.32 multiplier: one multiplier bit per cycle, product
// truncated toward zero and clamped to the signed 48-bit range.
module drm_mul import drm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [OPW-1:0] a_i,
  input  wire logic signed [OPW-1:0] b_i,
  output logic         [QW-1:0]      res_o,
  output mul_stat_t                  stat_o
);

  localparam int CNTW = $clog2(QW);
  localparam logic [CNTW-1:0] LAST = CNTW'(QW - 1);

  logic [QW-1:0]   a_q, b_q, hi_q, lo_q, res_q;
  logic [QW-1:0]   hi_d, lo_d, res_d;
  logic [OPW-1:0]  a_mag, b_mag;
  logic [QW:0]     sum;
  logic            neg_q, busy_q, done_q, ovf;
  logic [CNTW-1:0] cnt_q;
  logic [QW-2:0]   mag;

  assign a_mag = a_i[OPW-1] ? OPW'(-a_i) : OPW'(a_i);
  assign b_mag = b_i[OPW-1] ? OPW'(-b_i) : OPW'(b_i);

  // add the multiplicand when the low multiplier bit is set, then shift right
  assign sum  = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign hi_d = sum[QW:1];
  assign lo_d = {sum[0], lo_q[QW-1:1]};

  // the product is {hi_d, lo_d}; keep bits 78:32 and flag anything above
  assign ovf = |hi_d[QW-1:QW-17];
  assign mag = {hi_d[QW-18:0], lo_d[QW-1:32]};

  always_comb begin
    if (neg_q) begin
      res_d = ovf ? Q_MIN : QW'(-{1'b0, mag});
    end else begin
      res_d = ovf ? Q_MAX : {1'b0, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag[QW-1:0];
      b_q   <= b_mag[QW-1:0];
      neg_q <= a_i[OPW-1] ^ b_i[OPW-1];
      hi_q  <= '0;
      lo_q  <= '0;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
      b_q  <= b_q >> 1;
      if (cnt_q == LAST) begin
        res_q <= res_d;
      end
    end
  end

  assign res_o  = res_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

/* rtl/diode_ring_modulator_step.sv */
// Diode ring modulator step: each transfer on the input channel carries a dry
// sample and a modulator sample (signed Q1.23); the block advances a
// forward-Euler model of the ring (three node voltages, four diode voltages,
// two inductor currents, all saturating signed Q16.32) and returns one transfer
// with the new output node voltage u2 and a copy of the end-of-block flag.
// A micro-program of 81 steps runs on a single bit-serial multiplier that
// resolves one multiplier bit per cycle. Each of the 22 products passes
// through fetch, start, 48 multiplier bits and write-back; the 58 add and
// store steps each pass through fetch and execute. A new sample is taken once
// the previous one has left the sequencer; a finished result waits in the
// output register while the next sample is taken. Coefficients are written
// through the cfg port (index 0..5); the user must write them only while the
// block is idle, as the block itself does not enforce this; other indexes
// are ignored.
`timescale 1ns / 1ps
`default_nettype none

module diode_ring_modulator_step import drm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  drm_in_if.sink                in_i,
  drm_out_if.source             out_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CIDXW-1:0] cfg_idx_i,
  input  wire logic [QW-1:0]    cfg_data_i
);

  // coefficient registers
  logic [QW-1:0] step_over_c_q, step_over_cp_q, step_over_l_q;
  logic [QW-1:0] inv_load_r_q, inv_center_r_q, inv_mod_r_q;

  // sequencer
  state_e         state_q, state_d;
  logic [PCW-1:0] pc_q;
  uop_t           uop;

  // state file: registered reads at two addresses, one write port
  logic [QW-1:0]   rf_q [NREG];
  logic [NREG-1:0] vld_q;
  logic [QW-1:0]   rda_q, rdb_q;
  logic            rf_we;
  logic [RAW-1:0]  rf_wa;
  logic [QW-1:0]   rf_wd;

  // input latch, accumulator, output register
  logic signed [SAMPW-1:0] dry_q, mod_q;
  logic                    eob_q;
  logic signed [ACCW-1:0]  acc_q, acc_d, term;
  logic signed [OPW-1:0]   opa, opb, hterm;
  logic [QW-1:0]           acc_sat;
  logic                    out_valid_q, eob_out_q;
  logic [QW-1:0]           wet_q;

  // sequencer controls
  logic in_ready, mul_start, pc_inc, acc_we, st_we, out_load, in_xfer;

  logic [QW-1:0] mul_res;
  mul_stat_t     mul_stat;

  assign uop     = ucode(pc_q);
  assign in_xfer = in_i.valid && in_ready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_over_c_q  <= RST_STEP_OVER_C;
      step_over_cp_q <= RST_STEP_OVER_CP;
      step_over_l_q  <= RST_STEP_OVER_L;
      inv_load_r_q   <= RST_INV_LOAD_R;
      inv_center_r_q <= RST_INV_CENTER_R;
      inv_mod_r_q    <= RST_INV_MOD_R;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STEP_OVER_C:  step_over_c_q  <= cfg_data_i;
        CFG_STEP_OVER_CP: step_over_cp_q <= cfg_data_i;
        CFG_STEP_OVER_L:  step_over_l_q  <= cfg_data_i;
        CFG_INV_LOAD_R:   inv_load_r_q   <= cfg_data_i;
        CFG_INV_CENTER_R: inv_center_r_q <= cfg_data_i;
        CFG_INV_MOD_R:    inv_mod_r_q    <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // operand select: state file words are signed, coefficients unsigned
  // ---------------------------------------------------------------------------
  function automatic logic signed [OPW-1:0] pick(
    input src_e s, input logic [QW-1:0] rd);
    logic signed [OPW-1:0] v;
    v = '0;
    case (s)
      S_SC:   v = {1'b0, step_over_c_q};
      S_SCP:  v = {1'b0, step_over_cp_q};
      S_SL:   v = {1'b0, step_over_l_q};
      S_IRA:  v = {1'b0, inv_load_r_q};
      S_IRI:  v = {1'b0, inv_center_r_q};
      S_IRM:  v = {1'b0, inv_mod_r_q};
      S_K02:  v = {1'b0, K_POINT2};
      S_K017: v = {1'b0, K_POINT17};
      S_SDRY: v = {{(OPW-SAMPW-SAMP_SHIFT){dry_q[SAMPW-1]}}, dry_q, {SAMP_SHIFT{1'b0}}};
      S_SMOD: v = {{(OPW-SAMPW-SAMP_SHIFT){mod_q[SAMPW-1]}}, mod_q, {SAMP_SHIFT{1'b0}}};
      default: v = {rd[QW-1], rd};
    endcase
    return v;
  endfunction

  always_comb begin
    opa = pick(uop.sa, rda_q);
    opb = pick(uop.sb, rdb_q);
  end

  // ---------------------------------------------------------------------------
  // accumulator: halve (floor), negate, then add or load
  // ---------------------------------------------------------------------------
  assign hterm = uop.hlf ? (opa >>> 1) : opa;
  assign term  = uop.neg ? -ACCW'(hterm) : ACCW'(hterm);
  assign acc_d = uop.clr ? term : acc_q + term;

  // clamp to 48 bits when the top bits disagree
  always_comb begin
    if (acc_q[ACCW-1:QW-1] == '0 || acc_q[ACCW-1:QW-1] == '1) begin
      acc_sat = acc_q[QW-1:0];
    end else begin
      acc_sat = acc_q[ACCW-1] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // state file
  // ---------------------------------------------------------------------------
  assign rf_wa = uop.dst;
  assign rf_wd = st_we ? acc_sat : mul_res;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_wa] <= rf_wd;
    end
    if (state_q == ST_FETCH) begin
      rda_q <= (uop.sa < src_e'(NREG) && vld_q[uop.sa]) ? rf_q[uop.sa] : '0;
      rdb_q <= (uop.sb < src_e'(NREG) && vld_q[uop.sb]) ? rf_q[uop.sb] : '0;
    end
  end

  // unwritten entries read as zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (rf_we) begin
      vld_q[rf_wa] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // shared bit-serial multiplier
  // ---------------------------------------------------------------------------
  drm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .res_o   (mul_res),
    .stat_o  (mul_stat)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        case (uop.kind)
          K_MUL:   state_d = ST_MULW;
          K_DONE:  state_d = ST_OUT;
          default: state_d = ST_FETCH;
        endcase
      end
      ST_MULW:  if (mul_stat.done) state_d = ST_FETCH;
      ST_OUT:   if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    pc_inc    = 1'b0;
    acc_we    = 1'b0;
    st_we     = 1'b0;
    rf_we     = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: begin
        case (uop.kind)
          K_MUL: mul_start = 1'b1;
          K_ACC: begin
            acc_we = 1'b1;
            pc_inc = 1'b1;
          end
          K_ST: begin
            st_we  = 1'b1;
            rf_we  = 1'b1;
            pc_inc = 1'b1;
          end
          default: ;
        endcase
      end
      ST_MULW: begin
        rf_we  = mul_stat.done;
        pc_inc = mul_stat.done;
      end
      ST_OUT: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        pc_q <= '0;
      end else if (pc_inc) begin
        pc_q <= pc_q + 1'b1;
      end
    end
  end

  // hold the samples of the transfer being worked on
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dry_q <= in_i.dry_sample;
      mod_q <= in_i.mod_sample;
      eob_q <= in_i.end_of_block;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: the done step fetched u2 into rda_q
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      wet_q     <= rda_q;
      eob_out_q <= eob_q;
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.wet_sample       = wet_q;
  assign out_o.end_of_block_out = eob_out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_mul_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> state_q == ST_MULW)
    else $error("multiplier finished outside of a product wait");

  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result appeared without the sequencer finishing");

  a_pc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> pc_q < PCW'(PROG_LEN))
    else $error("micro-program counter ran past the program");

  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("product started while multiplier busy");

endmodule

`default_nettype wire
